// ===== design/bnc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnc_pkg: shared types and constants of the bracket nesting checker
// Field widths, status and kind codes, character codes, the bracket decoders
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bnc_pkg;

    // default stack size
    localparam int STACK_DEPTH_DEF = 32;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int KIND_W   = 2;
    localparam int POS_W    = 12;
    localparam int ODEPTH_W = 6;

    // character index saturates here
    localparam logic [POS_W-1:0] POS_MAX = 12'd4095;

    // line status codes
    localparam logic [STATUS_W-1:0] ST_BALANCED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CORRUPTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd3;

    // bracket kinds
    localparam logic [KIND_W-1:0] K_ROUND  = 2'd0;
    localparam logic [KIND_W-1:0] K_SQUARE = 2'd1;
    localparam logic [KIND_W-1:0] K_CURLY  = 2'd2;
    localparam logic [KIND_W-1:0] K_ANGLE  = 2'd3;

    // character codes
    localparam logic [CHAR_W-1:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [CHAR_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_CLOSE_ANGLE  = 8'h3E;

    // decoded bracket: hit flag and kind
    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
    } t_brk;

    // controller to datapath commands
    typedef struct packed {
        logic accept;       // process the accepted character
        logic load_status;  // load the end-of-line status result
        logic load_comp;    // load one completion closer and pop
        logic clear;        // clear all line state
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic incomplete;   // line clean with brackets still open
        logic depth_one;    // exactly one bracket open
    } t_dp_stat;

    function automatic t_brk opener_of(input logic [CHAR_W-1:0] c);
        t_brk r;
        r.hit  = 1'b1;
        r.kind = K_ROUND;
        case (c)
            CH_OPEN_ROUND:  r.kind = K_ROUND;
            CH_OPEN_SQUARE: r.kind = K_SQUARE;
            CH_OPEN_CURLY:  r.kind = K_CURLY;
            CH_OPEN_ANGLE:  r.kind = K_ANGLE;
            default:        r.hit  = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_brk closer_of(input logic [CHAR_W-1:0] c);
        t_brk r;
        r.hit  = 1'b1;
        r.kind = K_ROUND;
        case (c)
            CH_CLOSE_ROUND:  r.kind = K_ROUND;
            CH_CLOSE_SQUARE: r.kind = K_SQUARE;
            CH_CLOSE_CURLY:  r.kind = K_CURLY;
            CH_CLOSE_ANGLE:  r.kind = K_ANGLE;
            default:         r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/bracket_nesting_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_nesting_checker: four-kind bracket nesting checker
// Checks (), [], {} and <> nesting per line and reports status and closers.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while the checker takes input. A
// character that does not end a line produces no result. A line-end
// character is followed by a load of the status result, and for an
// incomplete line by a load of each needed closer, innermost first; input
// is held off during those loads, and each load waits while the output
// register still holds a result that is not taken. This sequencing is set
// by the single read port of the stack memory and the one-entry output
// register. The stack memory needs no clearing after reset; only entries
// below the current depth are ever used.
module bracket_nesting_checker
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic                i_line_end,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [KIND_W-1:0]        o_bracket_kind,
    output logic [POS_W-1:0]         o_error_position,
    output logic [ODEPTH_W-1:0]      o_open_depth,
    output logic                     o_is_completion,
    output logic                     o_run_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing
    bnc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_line_end  (i_line_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // stack and line state
    bnc_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_char_code      (i_char_code),
        .o_stat           (w_stat),
        .o_status         (o_status),
        .o_bracket_kind   (o_bracket_kind),
        .o_error_position (o_error_position),
        .o_open_depth     (o_open_depth),
        .o_is_completion  (o_is_completion),
        .o_run_last       (o_run_last)
    );

endmodule
`default_nettype wire

// ===== design/bnc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnc_datapath: bracket stack and line state
// Holds the opener stack memory with a registered top-of-stack read, the
// depth, error flags and character index, and the result payload registers.
// ----------------------------------------------------------------------------
module bnc_datapath
    import bnc_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    output t_dp_stat                 o_stat,
    output logic [STATUS_W-1:0]      o_status,
    output logic [KIND_W-1:0]        o_bracket_kind,
    output logic [POS_W-1:0]         o_error_position,
    output logic [ODEPTH_W-1:0]      o_open_depth,
    output logic                     o_is_completion,
    output logic                     o_run_last
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // line state
    logic [DW-1:0]     r_depth,    n_depth;
    logic              r_corrupt,  n_corrupt;
    logic              r_ovf,      n_ovf;
    logic [KIND_W-1:0] r_bad_kind, n_bad_kind;
    logic [POS_W-1:0]  r_char_idx, n_char_idx;
    logic [POS_W-1:0]  r_bad_idx,  n_bad_idx;

    // stack memory and registered top entry
    logic [KIND_W-1:0] r_mem [STACK_DEPTH];
    logic [KIND_W-1:0] r_top;

    // result payload
    logic [STATUS_W-1:0] r_status;
    logic [KIND_W-1:0]   r_kind;
    logic [POS_W-1:0]    r_epos;
    logic [ODEPTH_W-1:0] r_odepth;
    logic                r_comp;
    logic                r_last;

    t_brk          w_open;
    t_brk          w_close;
    logic          w_push;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_active;

    // character decode
    assign w_open    = opener_of(i_char_code);
    assign w_close   = closer_of(i_char_code);
    assign w_active  = i_cmd.accept && !r_corrupt && !r_ovf;
    assign w_push    = w_active && w_open.hit && (r_depth < DW'(STACK_DEPTH));
    assign w_wr_addr = r_depth[AW-1:0];

    // next line state
    always_comb begin
        n_depth    = r_depth;
        n_corrupt  = r_corrupt;
        n_ovf      = r_ovf;
        n_bad_kind = r_bad_kind;
        n_char_idx = r_char_idx;
        n_bad_idx  = r_bad_idx;
        if (i_cmd.clear) begin
            n_depth    = '0;
            n_corrupt  = 1'b0;
            n_ovf      = 1'b0;
            n_bad_kind = K_ROUND;
            n_char_idx = '0;
            n_bad_idx  = '0;
        end else if (i_cmd.load_comp) begin
            n_depth = r_depth - 1'b1;
        end else if (i_cmd.accept) begin
            if (r_char_idx != POS_MAX) begin
                n_char_idx = r_char_idx + 1'b1;
            end
            if (w_active) begin
                if (w_open.hit) begin
                    if (w_push) begin
                        n_depth = r_depth + 1'b1;
                    end else begin
                        n_ovf     = 1'b1;
                        n_bad_idx = r_char_idx;
                    end
                end else if (w_close.hit) begin
                    if (r_depth == '0 || r_top != w_close.kind) begin
                        n_corrupt  = 1'b1;
                        n_bad_kind = w_close.kind;
                        n_bad_idx  = r_char_idx;
                    end else begin
                        n_depth = r_depth - 1'b1;
                    end
                end
            end
        end
    end

    // top of stack after this cycle's update
    assign w_rd_addr = (n_depth == '0) ? '0 : AW'(n_depth - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_corrupt  <= 1'b0;
            r_ovf      <= 1'b0;
            r_bad_kind <= K_ROUND;
            r_char_idx <= '0;
            r_bad_idx  <= '0;
        end else begin
            r_depth    <= n_depth;
            r_corrupt  <= n_corrupt;
            r_ovf      <= n_ovf;
            r_bad_kind <= n_bad_kind;
            r_char_idx <= n_char_idx;
            r_bad_idx  <= n_bad_idx;
        end
    end

    // stack memory, write-first forwarding onto the top register
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[w_wr_addr] <= w_open.kind;
        end
        if (w_push && (w_rd_addr == w_wr_addr)) begin
            r_top <= w_open.kind;
        end else begin
            r_top <= r_mem[w_rd_addr];
        end
    end

    // result payload load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_status) begin
            r_comp <= 1'b0;
            if (r_corrupt) begin
                r_status <= ST_CORRUPTED;
                r_kind   <= r_bad_kind;
                r_epos   <= r_bad_idx;
                r_odepth <= ODEPTH_W'(r_depth);
                r_last   <= 1'b1;
            end else if (r_ovf) begin
                r_status <= ST_OVERFLOW;
                r_kind   <= K_ROUND;
                r_epos   <= r_bad_idx;
                r_odepth <= ODEPTH_W'(r_depth);
                r_last   <= 1'b1;
            end else if (r_depth == '0) begin
                r_status <= ST_BALANCED;
                r_kind   <= K_ROUND;
                r_epos   <= '0;
                r_odepth <= '0;
                r_last   <= 1'b1;
            end else begin
                r_status <= ST_INCOMPLETE;
                r_kind   <= K_ROUND;
                r_epos   <= '0;
                r_odepth <= ODEPTH_W'(r_depth);
                r_last   <= 1'b0;
            end
        end else if (i_cmd.load_comp) begin
            r_status <= ST_INCOMPLETE;
            r_kind   <= r_top;
            r_epos   <= '0;
            r_odepth <= ODEPTH_W'(r_depth - 1'b1);
            r_comp   <= 1'b1;
            r_last   <= (r_depth == DW'(1));
        end
    end

    // status toward the controller
    assign o_stat.incomplete = !r_corrupt && !r_ovf && (r_depth != '0);
    assign o_stat.depth_one  = (r_depth == DW'(1));

    assign o_status         = r_status;
    assign o_bracket_kind   = r_kind;
    assign o_error_position = r_epos;
    assign o_open_depth     = r_odepth;
    assign o_is_completion  = r_comp;
    assign o_run_last       = r_last;

endmodule
`default_nettype wire

// ===== design/bnc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bnc_ctrl: sequencing controller
// Takes characters, then at a line end issues the status result and walks
// the completion closers through the output register.
// ----------------------------------------------------------------------------
module bnc_ctrl
    import bnc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire logic     i_line_end,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_STAT = 2'd1;
    localparam logic [1:0] S_COMP = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_free;

    // output slot free when empty or being taken
    assign w_free     = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_RUN);

    // next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd.accept      = 1'b0;
        o_cmd.load_status = 1'b0;
        o_cmd.load_comp   = 1'b0;
        o_cmd.clear       = 1'b0;
        case (r_state)
            S_RUN: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_line_end) begin
                        n_state = S_STAT;
                    end
                end
            end
            S_STAT: begin
                if (w_free) begin
                    o_cmd.load_status = 1'b1;
                    if (i_stat.incomplete) begin
                        n_state = S_COMP;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            S_COMP: begin
                if (w_free) begin
                    o_cmd.load_comp = 1'b1;
                    if (i_stat.depth_one) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_status || o_cmd.load_comp) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // never load two results at once
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_status, o_cmd.load_comp}))
        else $error("status and completion loaded together");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_cmd.load_status || o_cmd.load_comp))
        else $error("result overwritten before taken");

    // incomplete status leads into the completion walk
    a_to_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_status && i_stat.incomplete) |=> (r_state == S_COMP))
        else $error("completion walk not started");

    // last completion returns to taking characters with a loaded result
    a_comp_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_comp && i_stat.depth_one) |=> (r_state == S_RUN && r_out_valid))
        else $error("completion walk did not finish");
`endif

endmodule
`default_nettype wire

// ===== test/tb_bracket_nesting_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bracket_nesting_checker: self-checking bench for the bracket nesting checker
// Streams lines of characters through the request channel and predicts every
// status and completion result from its own nesting tracker. Results are
// compared in order, field by field. Both channels idle and stall at random.
// Directed lines come first, then random lines with random nesting.
// ----------------------------------------------------------------------------
module tb_bracket_nesting_checker;
    import bnc_pkg::*;

    localparam int NEST_MAX = STACK_DEPTH_DEF;

    // one character request as queued for the driver
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              le;
        bit                calm;
        bit                drain;
    } t_char_req;

    // one predicted result
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [KIND_W-1:0]   kind;
        logic [POS_W-1:0]    pos;
        logic [ODEPTH_W-1:0] depth;
        logic                comp;
        logic                last;
    } t_line_report;

    typedef enum int {LN_BALANCED, LN_OPEN, LN_BROKEN, LN_DEEP, LN_NOISE} t_line_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [CHAR_W-1:0]     i_char_code = '0;
    logic                  i_line_end = 1'b0;
    logic                  i_out_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [KIND_W-1:0]     o_bracket_kind;
    logic [POS_W-1:0]      o_error_position;
    logic [ODEPTH_W-1:0]   o_open_depth;
    logic                  o_is_completion;
    logic                  o_run_last;

    t_char_req    char_q[$];
    t_line_report report_q[$];
    int           bad_count = 0;
    int           counted = 0;

    // nesting tracker state
    logic [KIND_W-1:0] nest_stack [0:NEST_MAX-1];
    int                nest_depth = 0;
    bit                line_corrupt = 1'b0;
    bit                line_overflow = 1'b0;
    logic [KIND_W-1:0] bad_kind = '0;
    logic [POS_W-1:0]  char_pos = '0;
    logic [POS_W-1:0]  bad_pos = '0;

    // driver state
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;
    bit   presenting = 1'b0;
    bit   gap_drawn = 1'b0;
    bit   calm_now = 1'b0;
    int   gap_left = 0;
    int   res_hold = 0;

    bracket_nesting_checker #(
        .STACK_DEPTH(NEST_MAX)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_char_code      (i_char_code),
        .i_line_end       (i_line_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_bracket_kind   (o_bracket_kind),
        .o_error_position (o_error_position),
        .o_open_depth     (o_open_depth),
        .o_is_completion  (o_is_completion),
        .o_run_last       (o_run_last)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("bracket_nesting_checker verification failed");
        $finish;
    end

    // character decoders, -1 for anything that is not a bracket
    function automatic int opener_code(input logic [CHAR_W-1:0] c);
        case (c)
            CH_OPEN_ROUND:  return K_ROUND;
            CH_OPEN_SQUARE: return K_SQUARE;
            CH_OPEN_CURLY:  return K_CURLY;
            CH_OPEN_ANGLE:  return K_ANGLE;
            default:        return -1;
        endcase
    endfunction

    function automatic int closer_code(input logic [CHAR_W-1:0] c);
        case (c)
            CH_CLOSE_ROUND:  return K_ROUND;
            CH_CLOSE_SQUARE: return K_SQUARE;
            CH_CLOSE_CURLY:  return K_CURLY;
            CH_CLOSE_ANGLE:  return K_ANGLE;
            default:         return -1;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] open_char(input logic [KIND_W-1:0] k);
        case (k)
            K_ROUND:  return CH_OPEN_ROUND;
            K_SQUARE: return CH_OPEN_SQUARE;
            K_CURLY:  return CH_OPEN_CURLY;
            default:  return CH_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] close_char(input logic [KIND_W-1:0] k);
        case (k)
            K_ROUND:  return CH_CLOSE_ROUND;
            K_SQUARE: return CH_CLOSE_SQUARE;
            K_CURLY:  return CH_CLOSE_CURLY;
            default:  return CH_CLOSE_ANGLE;
        endcase
    endfunction

    // random byte that is never a bracket
    function automatic logic [CHAR_W-1:0] filler();
        logic [CHAR_W-1:0] c;
        c = CHAR_W'($urandom_range(0, 255));
        if (opener_code(c) >= 0 || closer_code(c) >= 0)
            c = 8'h2E;
        return c;
    endfunction

    function automatic int draw_wait();
        return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, 19));
    endfunction

    function automatic void queue_report(input logic [STATUS_W-1:0] st,
                                         input logic [KIND_W-1:0] k,
                                         input logic [POS_W-1:0] pos,
                                         input int depth, input logic comp,
                                         input logic last);
        t_line_report r;
        r.status = st;
        r.kind   = k;
        r.pos    = pos;
        r.depth  = ODEPTH_W'(depth);
        r.comp   = comp;
        r.last   = last;
        report_q.insert(report_q.size(), r);
    endfunction

    // nesting tracker: updates line state and queues the results of a line end
    task automatic track_char(input logic [CHAR_W-1:0] ch, input logic le);
        int ok;
        int ck;
        int d;
        ok = opener_code(ch);
        ck = closer_code(ch);
        if (!line_corrupt && !line_overflow) begin
            if (ok >= 0) begin
                if (nest_depth < NEST_MAX) begin
                    nest_stack[nest_depth] = KIND_W'(ok);
                    nest_depth++;
                end else begin
                    line_overflow = 1'b1;
                    bad_pos       = char_pos;
                end
            end else if (ck >= 0) begin
                if (nest_depth == 0 || nest_stack[nest_depth-1] != KIND_W'(ck)) begin
                    line_corrupt = 1'b1;
                    bad_kind     = KIND_W'(ck);
                    bad_pos      = char_pos;
                end else begin
                    nest_depth--;
                end
            end
        end
        if (char_pos != POS_MAX)
            char_pos++;
        if (le) begin
            if (line_corrupt) begin
                queue_report(ST_CORRUPTED, bad_kind, bad_pos, nest_depth, 1'b0, 1'b1);
            end else if (line_overflow) begin
                queue_report(ST_OVERFLOW, K_ROUND, bad_pos, nest_depth, 1'b0, 1'b1);
            end else if (nest_depth == 0) begin
                queue_report(ST_BALANCED, K_ROUND, '0, 0, 1'b0, 1'b1);
            end else begin
                // status first, then the needed closers innermost first
                d = nest_depth;
                queue_report(ST_INCOMPLETE, K_ROUND, '0, d, 1'b0, 1'b0);
                while (d > 0) begin
                    d--;
                    queue_report(ST_INCOMPLETE, nest_stack[d], '0, d, 1'b1, d == 0);
                end
            end
            nest_depth    = 0;
            line_corrupt  = 1'b0;
            line_overflow = 1'b0;
            bad_kind      = '0;
            char_pos      = '0;
            bad_pos       = '0;
        end
    endtask

    // stimulus helpers
    task automatic add_char(input logic [CHAR_W-1:0] ch, input logic le,
                            input bit calm, input bit drain);
        t_char_req r;
        r.ch    = ch;
        r.le    = le;
        r.calm  = calm;
        r.drain = drain;
        char_q.insert(char_q.size(), r);
        counted++;
    endtask

    task automatic add_text(input logic [CHAR_W-1:0] txt[$], input bit calm,
                            input bit drain);
        for (int i = 0; i < txt.size(); i++)
            add_char(txt[i], i == txt.size() - 1, calm, drain && i == 0);
    endtask

    // builds one line of the given shape with random content
    task automatic gen_line(input t_line_shape shape, input int deep_n,
                            input bit calm, input bit drain);
        logic [CHAR_W-1:0] txt[$];
        logic [KIND_W-1:0] opn[$];
        logic [KIND_W-1:0] k;
        int steps;
        int pick;
        int closes;
        if (shape == LN_NOISE) begin
            steps = $urandom_range(1, 8);
            repeat (steps) txt.insert(txt.size(), CHAR_W'($urandom_range(0, 255)));
        end else if (shape == LN_DEEP) begin
            for (int i = 0; i < deep_n; i++) begin
                k = KIND_W'($urandom_range(0, 3));
                txt.insert(txt.size(), open_char(k));
                opn.insert(opn.size(), k);
            end
            closes = (deep_n >= NEST_MAX) ? 0 : int'($urandom_range(0, 3));
            repeat (closes) txt.insert(txt.size(), close_char(opn.pop_back()));
            // brackets after an overflow are ignored
            if (deep_n > NEST_MAX)
                txt.insert(txt.size(),
                           $urandom_range(0, 1) ? open_char(KIND_W'($urandom_range(0, 3)))
                                                : close_char(KIND_W'($urandom_range(0, 3))));
        end else begin
            // random well-formed prefix
            steps = $urandom_range(0, 16);
            repeat (steps) begin
                pick = $urandom_range(0, 9);
                if (pick < 4 && opn.size() < 12) begin
                    k = KIND_W'($urandom_range(0, 3));
                    txt.insert(txt.size(), open_char(k));
                    opn.insert(opn.size(), k);
                end else if (pick < 7 && opn.size() > 0) begin
                    txt.insert(txt.size(), close_char(opn.pop_back()));
                end else begin
                    txt.insert(txt.size(), filler());
                end
            end
            case (shape)
                LN_BALANCED: begin
                    while (opn.size() > 0) txt.insert(txt.size(), close_char(opn.pop_back()));
                end
                LN_OPEN: begin
                    if (opn.size() == 0)
                        txt.insert(txt.size(), open_char(KIND_W'($urandom_range(0, 3))));
                end
                default: begin
                    // wrong closer, or any closer on an empty stack
                    if (opn.size() > 0)
                        k = opn[opn.size()-1] + KIND_W'($urandom_range(1, 3));
                    else
                        k = KIND_W'($urandom_range(0, 3));
                    txt.insert(txt.size(), close_char(k));
                    steps = $urandom_range(0, 4);
                    repeat (steps)
                        txt.insert(txt.size(), $urandom_range(0, 1)
                            ? open_char(KIND_W'($urandom_range(0, 3)))
                            : close_char(KIND_W'($urandom_range(0, 3))));
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                txt.insert(txt.size(), filler());
        end
        if (txt.size() == 0)
            txt.insert(txt.size(), filler());
        add_text(txt, calm, drain);
    endtask

    // driver: request side and result-side stalls, all changes at the falling edge
    always @(negedge i_clk) begin : driver
        if (i_rst_n) begin
            if (req_taken) begin
                presenting = 1'b0;
                gap_drawn  = 1'b0;
            end
            if (!presenting && char_q.size() > 0) begin
                if (!gap_drawn) begin
                    gap_left  = char_q[0].calm ? 0 : draw_wait();
                    gap_drawn = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!char_q[0].drain || report_q.size() == 0)
                    presenting = 1'b1;
            end
            if (presenting) begin
                calm_now = char_q[0].calm;
                i_char_code <= char_q[0].ch;
                i_line_end  <= char_q[0].le;
            end
            i_in_valid <= presenting;

            // result side stall drawn per result
            if (res_taken)
                res_hold = calm_now ? 0 : draw_wait();
            if (res_hold > 0) begin
                res_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // monitor: accepted requests feed the tracker, accepted results are checked
    always @(posedge i_clk) begin : monitor
        t_line_report want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                void'(char_q.pop_front());
                track_char(i_char_code, i_line_end);
            end
            if (o_out_valid && i_out_ready) begin
                if (report_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result: st=%0d kind=%0d pos=%0d depth=%0d comp=%0d last=%0d",
                                 o_status, o_bracket_kind, o_error_position, o_open_depth,
                                 o_is_completion, o_run_last);
                end else begin
                    want = report_q.pop_front();
                    if (o_status !== want.status || o_bracket_kind !== want.kind ||
                        o_error_position !== want.pos || o_open_depth !== want.depth ||
                        o_is_completion !== want.comp || o_run_last !== want.last) begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"mismatch: exp st=%0d kind=%0d pos=%0d depth=%0d comp=%0d",
                                      " last=%0d, got st=%0d kind=%0d pos=%0d depth=%0d",
                                      " comp=%0d last=%0d"},
                                     want.status, want.kind, want.pos, want.depth, want.comp,
                                     want.last, o_status, o_bracket_kind, o_error_position,
                                     o_open_depth, o_is_completion, o_run_last);
                    end
                end
            end
        end
        req_taken <= i_rst_n && i_in_valid && o_in_ready;
        res_taken <= i_rst_n && o_out_valid && i_out_ready;
    end

    // stimulus and end of run
    initial begin : stimulus
        logic [CHAR_W-1:0] txt[$];
        t_line_shape shape;
        bit calm;
        int pick;
        int n_lines;

        // empty line: non-bracket end on an empty stack
        add_char(8'h61, 1'b1, 1'b0, 1'b0);
        // every kind opened and closed
        txt = '{CH_OPEN_ROUND, CH_CLOSE_ROUND, CH_OPEN_SQUARE, CH_CLOSE_SQUARE,
                CH_OPEN_CURLY, CH_CLOSE_CURLY, CH_OPEN_ANGLE, CH_CLOSE_ANGLE};
        add_text(txt, 1'b0, 1'b0);
        // incomplete, every kind needed as a closer
        txt = '{CH_OPEN_ROUND, CH_OPEN_SQUARE, CH_OPEN_CURLY, CH_OPEN_ANGLE};
        add_text(txt, 1'b0, 1'b0);
        // closer on an empty stack
        add_char(CH_CLOSE_ROUND, 1'b1, 1'b0, 1'b0);
        // mismatching closer, later brackets ignored
        txt = '{CH_OPEN_ROUND, CH_CLOSE_SQUARE, CH_CLOSE_CURLY, 8'h78};
        add_text(txt, 1'b0, 1'b0);
        add_char(CH_CLOSE_ANGLE, 1'b1, 1'b0, 1'b0);
        // byte extremes
        add_char(8'h00, 1'b0, 1'b0, 1'b0);
        add_char(8'hFF, 1'b1, 1'b0, 1'b0);

        // full stack with every closer needed, then overflow
        gen_line(LN_DEEP, NEST_MAX, 1'b0, 1'b1);
        gen_line(LN_DEEP, NEST_MAX + 1, 1'b0, 1'b0);

        // random lines, mostly well formed, in groups with or without idling
        n_lines = 0;
        calm    = 1'b0;
        while (counted < 270) begin
            if (n_lines % 8 == 0)
                calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)       shape = LN_BALANCED;
            else if (pick < 6)  shape = LN_OPEN;
            else if (pick < 8)  shape = LN_BROKEN;
            else if (pick == 8) shape = LN_DEEP;
            else                shape = LN_NOISE;
            gen_line(shape, $urandom_range(28, 34), calm, $urandom_range(0, 9) == 0);
            n_lines++;
        end

        // reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() != 0 || report_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        if (bad_count == 0)
            $display("bracket_nesting_checker verification clean");
        else
            $display("bracket_nesting_checker verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/bnc_pkg.sv
design/bnc_datapath.sv
design/bnc_ctrl.sv
design/bracket_nesting_checker.sv
test/tb_bracket_nesting_checker.sv
